// ===== sv/depth_colormap_decimate_mirror_defines.svh =====
`ifndef DEPTH_COLORMAP_DECIMATE_MIRROR_DEFINES_SVH
`define DEPTH_COLORMAP_DECIMATE_MIRROR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcdm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcdm check failed");

`endif

// ===== sv/dcdm_pkg.sv =====
`default_nettype none

package dcdm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int DEPTH_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // jet ramp over 300..4000 mm
    localparam int DEPTH_LO    = 300;
    localparam int DEPTH_HI    = 4000;
    localparam int RAMP_OFFSET = 2775;
    localparam int RAMP_SPAN   = 1850;
    localparam int NUM_W       = 11;

    // floor(n * 255 / 1850) as (n * RECIP_K) >> RECIP_SHIFT, exact for n <= 1850
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_K     = 2312536;
    localparam int RECIP_W     = 22;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } px_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dcdm_ifs.sv =====
`default_nettype none

interface dcdm_in_if;
    logic                         valid;
    logic                         ready;
    logic [dcdm_pkg::DEPTH_W-1:0] sample_mm;
    logic                         frame_start;

    modport source (output valid, output sample_mm, output frame_start, input ready);
    modport sink   (input valid, input sample_mm, input frame_start, output ready);
endinterface

interface dcdm_out_if;
    logic                        valid;
    logic                        ready;
    logic [dcdm_pkg::CHAN_W-1:0] red;
    logic [dcdm_pkg::CHAN_W-1:0] green;
    logic [dcdm_pkg::CHAN_W-1:0] blue;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, output red, output green, output blue,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input row_end, input frame_end, output ready);
endinterface

interface dcdm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dcdm_pkg::CFG_IDX_W-1:0] index;
    logic [dcdm_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dcdm_ram.sv =====
`default_nettype none

module dcdm_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 512,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/dcdm_raster.sv =====
`default_nettype none

`include "depth_colormap_decimate_mirror_defines.svh"

module dcdm_raster #(
    parameter  int MAX_WIDTH  = dcdm_pkg::MAX_WIDTH_DEF,
    parameter  int MAX_HEIGHT = dcdm_pkg::MAX_HEIGHT_DEF,
    localparam int AW         = $clog2(MAX_WIDTH / 2)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    dcdm_in_if.sink                           depth,
    dcdm_cfg_if.sink                          cfg,
    output logic                              ram_we,
    output logic [AW-1:0]                     ram_waddr,
    output logic [dcdm_pkg::DEPTH_W-1:0]      ram_wdata,
    output logic                              ram_re,
    output logic [AW-1:0]                     ram_raddr,
    output logic                              s1_valid,
    output dcdm_pkg::px_ctrl_t                s1_ctrl,
    input  wire logic                         s1_ready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int FW = dcdm_pkg::CFG_W;

    logic [FW-1:0]      width_reg;
    logic [FW-1:0]      height_reg;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic               s1_valid_reg;
    dcdm_pkg::px_ctrl_t s1_ctrl_reg;
    dcdm_pkg::px_ctrl_t ctrl_next;

    logic [WW-1:0] w_eff;
    logic [WW-1:0] ow;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] oh;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [WW-1:0] col_x;
    logic [HW-1:0] row_x;
    logic [WW-1:0] mirror_off;
    logic [WW-1:0] ox;
    logic [HW-1:0] oy;
    logic          in_frame;
    logic          fire;
    logic          last_px;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW'(dcdm_pkg::RESET_WIDTH);
            height_reg <= FW'(dcdm_pkg::RESET_HEIGHT);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dcdm_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg.data;
                dcdm_pkg::REG_FRAME_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // saturate the programmed geometry
    always_comb
    begin
        if (32'(width_reg) < 32'd2)
            w_eff = WW'(2);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (32'(height_reg) < 32'd1)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    assign ow = w_eff >> 1;
    assign oh = h_eff >> 1;

    assign fire  = depth.valid && depth.ready;
    assign col   = depth.frame_start ? '0 : col_reg;
    assign row   = depth.frame_start ? '0 : row_reg;
    assign col_x = WW'(col);
    assign row_x = HW'(row);

    assign in_frame   = (col_x < w_eff) && (row_x < h_eff);
    assign mirror_off = w_eff - col_x - WW'(1);
    assign ox         = mirror_off >> 1;
    assign oy         = HW'(row >> 1);
    assign last_px    = (col_x == ow - WW'(1));

    // even rows fill the line at the mirrored position, odd rows drain it
    assign ram_we    = fire && in_frame && !row[0] && !mirror_off[0] && (ox < ow);
    assign ram_waddr = ox[AW-1:0];
    assign ram_wdata = depth.sample_mm;
    assign ram_re    = fire && in_frame && row[0] && (col_x < ow) && (oy < oh);
    assign ram_raddr = col[AW-1:0];

    assign ctrl_next.row_end   = last_px;
    assign ctrl_next.frame_end = last_px && (oy == oh - HW'(1));

    always_comb
    begin
        if (col_x + WW'(1) >= w_eff)
        begin
            col_next = '0;
            if (row_x + HW'(1) >= h_eff)
                row_next = '0;
            else
                row_next = RW'(row_x + HW'(1));
        end
        else
        begin
            col_next = CW'(col_x + WW'(1));
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 follows the line RAM read latency
    assign depth.ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (depth.ready)
        begin
            s1_valid_reg <= ram_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_ctrl_reg <= ctrl_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;

    `DCDM_ASSERT_NOW(a_we_re_excl, clk, rst_n, ram_we, !ram_re)
    `DCDM_ASSERT_NOW(a_frame_end_row_end, clk, rst_n, s1_valid_reg && s1_ctrl_reg.frame_end, s1_ctrl_reg.row_end)
    `DCDM_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_ready, s1_valid_reg && $stable(s1_ctrl_reg))

endmodule

`default_nettype wire

// ===== sv/dcdm_color.sv =====
`default_nettype none

module dcdm_color (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dcdm_pkg::DEPTH_W-1:0] sample_mm,
    input  wire dcdm_pkg::px_ctrl_t           in_ctrl,
    dcdm_out_if.source                        color
);

    localparam int NW = dcdm_pkg::NUM_W;
    localparam int PW = dcdm_pkg::PROD_W;
    localparam int KW = dcdm_pkg::CHAN_W;
    localparam int DW = dcdm_pkg::DEPTH_W;

    function automatic logic [NW-1:0] sat_num(input logic signed [13:0] n);
        logic [NW-1:0] r;
        if (n < 0)
            r = '0;
        else if (n > 14'(dcdm_pkg::RAMP_SPAN))
            r = NW'(dcdm_pkg::RAMP_SPAN);
        else
            r = n[NW-1:0];
        return r;
    endfunction

    logic [11:0]        d12;
    logic [11:0]        u;
    logic [NW-1:0]      dev;
    logic [12:0]        two_u;
    logic signed [13:0] red_n;
    logic signed [13:0] green_n;
    logic signed [13:0] blue_n;
    logic [NW-1:0]      red_sat;
    logic [NW-1:0]      green_sat;
    logic [NW-1:0]      blue_sat;

    logic               s2_valid_reg;
    dcdm_pkg::px_ctrl_t s2_ctrl_reg;
    logic [NW-1:0]      red_num_reg;
    logic [NW-1:0]      green_num_reg;
    logic [NW-1:0]      blue_num_reg;

    logic [PW-1:0] red_prod;
    logic [PW-1:0] green_prod;
    logic [PW-1:0] blue_prod;

    logic               out_valid_reg;
    logic [KW-1:0]      red_reg;
    logic [KW-1:0]      green_reg;
    logic [KW-1:0]      blue_reg;
    dcdm_pkg::px_ctrl_t out_ctrl_reg;
    logic               out_adv;

    // ramp numerators, each clamped to 0..1850
    always_comb
    begin
        if (sample_mm < DW'(dcdm_pkg::DEPTH_LO))
            d12 = 12'(dcdm_pkg::DEPTH_LO);
        else if (sample_mm > DW'(dcdm_pkg::DEPTH_HI))
            d12 = 12'(dcdm_pkg::DEPTH_HI);
        else
            d12 = sample_mm[11:0];

        u = 12'(dcdm_pkg::DEPTH_HI) - d12;
        if (u >= 12'(dcdm_pkg::RAMP_SPAN))
            dev = NW'(u - 12'(dcdm_pkg::RAMP_SPAN));
        else
            dev = NW'(12'(dcdm_pkg::RAMP_SPAN) - u);
        two_u = {u, 1'b0};

        red_n   = $signed(14'(two_u)) - $signed(14'(dcdm_pkg::RAMP_OFFSET));
        green_n = $signed(14'(dcdm_pkg::RAMP_OFFSET)) - $signed(14'({dev, 1'b0}));
        blue_n  = $signed(14'(dcdm_pkg::RAMP_OFFSET)) - $signed(14'(two_u));

        // no reading: black
        if (sample_mm == '0)
        begin
            red_sat   = '0;
            green_sat = '0;
            blue_sat  = '0;
        end
        else
        begin
            red_sat   = sat_num(red_n);
            green_sat = sat_num(green_n);
            blue_sat  = sat_num(blue_n);
        end
    end

    assign out_adv  = !out_valid_reg || color.ready;
    assign in_ready = !s2_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s2_ctrl_reg   <= in_ctrl;
            red_num_reg   <= red_sat;
            green_num_reg <= green_sat;
            blue_num_reg  <= blue_sat;
        end
    end

    // scale by 255/1850 with a reciprocal multiply
    assign red_prod   = PW'(red_num_reg) * PW'(dcdm_pkg::RECIP_K);
    assign green_prod = PW'(green_num_reg) * PW'(dcdm_pkg::RECIP_K);
    assign blue_prod  = PW'(blue_num_reg) * PW'(dcdm_pkg::RECIP_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            red_reg      <= red_prod[dcdm_pkg::RECIP_SHIFT +: KW];
            green_reg    <= green_prod[dcdm_pkg::RECIP_SHIFT +: KW];
            blue_reg     <= blue_prod[dcdm_pkg::RECIP_SHIFT +: KW];
            out_ctrl_reg <= s2_ctrl_reg;
        end
    end

    assign color.valid     = out_valid_reg;
    assign color.red       = red_reg;
    assign color.green     = green_reg;
    assign color.blue      = blue_reg;
    assign color.row_end   = out_ctrl_reg.row_end;
    assign color.frame_end = out_ctrl_reg.frame_end;

endmodule

`default_nettype wire

// ===== sv/depth_colormap_decimate_mirror.sv =====
// Path: an odd-row word read back from the line RAM passes the RAM read register, loaded
//   at the accepting edge, then the ramp numerator register, then the reciprocal multiply
//   into the output register. Throughput: one depth word per cycle unless color stalls;
//   the line RAM takes at most one write or one read per word.
// Reset: clears row and column counters and pipeline valids, and sets frame_width to 640
//   and frame_height to 480; the line RAM is not cleared and needs no clearing pass.
`default_nettype none

module depth_colormap_decimate_mirror #(
    parameter int MAX_WIDTH  = dcdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dcdm_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcdm_in_if.sink    depth,
    dcdm_cfg_if.sink   cfg,
    dcdm_out_if.source color
);

    localparam int AW = $clog2(MAX_WIDTH / 2);

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [dcdm_pkg::DEPTH_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [dcdm_pkg::DEPTH_W-1:0] ram_rdata;
    logic                         s1_valid;
    logic                         s1_ready;
    dcdm_pkg::px_ctrl_t           s1_ctrl;

    dcdm_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .s1_valid  (s1_valid),
        .s1_ctrl   (s1_ctrl),
        .s1_ready  (s1_ready)
    );

    dcdm_ram #(
        .WIDTH (dcdm_pkg::DEPTH_W),
        .DEPTH (MAX_WIDTH / 2)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dcdm_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .sample_mm (ram_rdata),
        .in_ctrl   (s1_ctrl),
        .color     (color)
    );

endmodule

`default_nettype wire
